### src/idq_pkg.sv
// ----------------------------------------------------------------------------
// idq_pkg
// Shared types and constants of the indexed deque: request kinds, port
// widths and the command broadcast from the control unit to the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package idq_pkg;

  // Default configuration
  localparam int DEPTH_DEF      = 64;
  localparam int WORD_WIDTH_DEF = 32;

  // Fixed field widths of the request and response channels
  localparam int KIND_W = 3;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 7;

  // Slot index width in the command; covers the largest supported depth
  localparam int IDX_MAX_W = 11;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_BACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_AT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT = 3'd4;

  // Command broadcast to every cell
  typedef struct packed {
    logic                 shift_en;    // cells at or above shift_from take neighbor word
    logic [IDX_MAX_W-1:0] shift_from;
    logic                 wr_en;       // cell wr_idx loads the pushed word
    logic [IDX_MAX_W-1:0] wr_idx;
    logic [IDX_MAX_W-1:0] rd_idx;      // cell that drives the read bus
  } idq_cmd_t;

endpackage

`default_nettype wire

### src/idq_ifs.sv
// ----------------------------------------------------------------------------
// idq request / response interfaces
// Valid/ready channels carrying one deque request and one deque response.
// ----------------------------------------------------------------------------
`default_nettype none

interface idq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [5:0]  position;
  logic [31:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface idq_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_out;
  logic        error;
  logic [6:0]  occupancy;

  modport source (output valid, data_out, error, occupancy, input ready);
  modport sink   (input valid, data_out, error, occupancy, output ready);
endinterface

`default_nettype wire

### src/indexed_deque.sv
// ----------------------------------------------------------------------------
// indexed_deque
// Bounded double-ended queue with indexed read and order-keeping removal,
// built as a row of storage cells under one control unit.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   in_req    in    valid/ready    kind[2:0], position[5:0], value[31:0]
//   out_rsp   out   valid/ready    data_out[31:0], error, occupancy[6:0]
//
// The response to each request is registered at the edge that takes the
// request and shows up on out_rsp in the next cycle.
// Pop front and remove shift every cell above the slot down by one in that
// same edge, so throughput is one request per cycle while out_rsp drains.
// Reset clears the fill count and response valid and holds in_req.ready low;
// cell contents are left.
// A stalled response holds in the output register, and a new request is
// taken only when that register is empty or being read.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_deque #(
  parameter int DEPTH      = idq_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = idq_pkg::WORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  idq_req_if.sink   in_req,
  idq_rsp_if.source out_rsp
);
  import idq_pkg::*;

  idq_cmd_t              cmd;
  logic [WORD_WIDTH-1:0] wr_data;
  logic [WORD_WIDTH-1:0] rd_word;

  // Cell i hands its word down to cell i-1; the top cell takes zero
  logic [WORD_WIDTH-1:0] words    [DEPTH];
  logic [WORD_WIDTH-1:0] hit_words[DEPTH];

  // Decode, check and register the response
  idq_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (in_req),
    .rsp     (out_rsp),
    .cmd     (cmd),
    .wr_data (wr_data),
    .rd_word (rd_word)
  );

  // Row of storage cells, slot 0 is the front of the queue
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] nbr;
    if (i == DEPTH - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = words[i+1];
    end

    idq_cell #(
      .IDX        (i),
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .wr_data  (wr_data),
      .nbr_word (nbr),
      .word     (words[i]),
      .hit_word (hit_words[i])
    );
  end

  // Collect the selected cell onto the read bus; only one cell drives it
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_word = rd_word | hit_words[k];
    end
  end

endmodule

`default_nettype wire

### src/idq_cell.sv
// ----------------------------------------------------------------------------
// idq_cell
// One storage slot of the deque. Takes its upper neighbor's word on a shift,
// loads the pushed word when addressed, and drives the read bus when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module idq_cell #(
  parameter int IDX        = 0,
  parameter int WORD_WIDTH = idq_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire idq_pkg::idq_cmd_t     cmd,
  input  wire logic [WORD_WIDTH-1:0] wr_data,
  input  wire logic [WORD_WIDTH-1:0] nbr_word,
  output logic      [WORD_WIDTH-1:0] word,
  output logic      [WORD_WIDTH-1:0] hit_word
);
  import idq_pkg::*;

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (cmd.shift_en && (MY_IDX >= cmd.shift_from)) begin
      word_nxt = nbr_word;
    end else if (cmd.wr_en && (MY_IDX == cmd.wr_idx)) begin
      word_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word     = word_r;
  assign hit_word = (MY_IDX == cmd.rd_idx) ? word_r : '0;

endmodule

`default_nettype wire

### src/idq_ctrl.sv
// ----------------------------------------------------------------------------
// idq_ctrl
// Decodes each request, checks it against the fill count, drives the cell
// command and holds the response in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module idq_ctrl #(
  parameter int DEPTH      = idq_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = idq_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  idq_req_if.sink                    req,
  idq_rsp_if.source                  rsp,
  output idq_pkg::idq_cmd_t          cmd,
  output logic      [WORD_WIDTH-1:0] wr_data,
  input  wire logic [WORD_WIDTH-1:0] rd_word
);
  import idq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int VW    = (WORD_WIDTH < VAL_W) ? WORD_WIDTH : VAL_W;
  localparam int DW    = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
  localparam int OW    = (CNT_W < OCC_W) ? CNT_W : OCC_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] data_out_r, data_out_nxt;
  logic              error_r, err_c;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic              acc;
  logic              use_rd;
  logic              empty, full, pos_ok;
  idq_cmd_t          cmd_c;

  assign empty  = (fill_r == '0);
  assign full   = (fill_r == FULL_CNT);
  assign pos_ok = (PW'(req.position) < PW'(fill_r));

  // Accept whenever the response slot is free or being drained, never in reset
  assign req.ready = rst_n && (!out_valid_r || rsp.ready);
  assign acc       = req.valid && req.ready;

  always_comb begin
    wr_data         = '0;
    wr_data[VW-1:0] = req.value[VW-1:0];
  end

  always_comb begin
    cmd_c            = '0;
    cmd_c.wr_idx     = IDX_MAX_W'(fill_r);
    cmd_c.rd_idx     = IDX_MAX_W'(req.position);
    cmd_c.shift_from = IDX_MAX_W'(req.position);
    fill_nxt         = fill_r;
    err_c            = 1'b1;
    use_rd           = 1'b0;
    case (req.kind)
      KIND_PUSH_BACK: begin
        err_c = full;
        if (!full) begin
          cmd_c.wr_en = 1'b1;
          fill_nxt    = fill_r + CNT_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        err_c            = empty;
        cmd_c.rd_idx     = '0;
        cmd_c.shift_from = '0;
        if (!empty) begin
          cmd_c.shift_en = 1'b1;
          use_rd         = 1'b1;
          fill_nxt       = fill_r - CNT_W'(1);
        end
      end
      KIND_POP_BACK: begin
        err_c        = empty;
        cmd_c.rd_idx = IDX_MAX_W'(fill_r - CNT_W'(1));
        if (!empty) begin
          use_rd   = 1'b1;
          fill_nxt = fill_r - CNT_W'(1);
        end
      end
      KIND_READ_AT: begin
        err_c  = !pos_ok;
        use_rd = pos_ok;
      end
      KIND_REMOVE_AT: begin
        err_c = !pos_ok;
        if (pos_ok) begin
          cmd_c.shift_en = 1'b1;
          use_rd         = 1'b1;
          fill_nxt       = fill_r - CNT_W'(1);
        end
      end
      default: begin
        err_c = 1'b1;
      end
    endcase
    // Hold the cells unless the request is taken
    if (!acc) begin
      cmd_c.shift_en = 1'b0;
      cmd_c.wr_en    = 1'b0;
    end
  end

  assign cmd = cmd_c;

  always_comb begin
    data_out_nxt = '0;
    if (use_rd) begin
      data_out_nxt[DW-1:0] = rd_word[DW-1:0];
    end
    occ_nxt         = '0;
    occ_nxt[OW-1:0] = fill_nxt[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      data_out_r <= data_out_nxt;
      error_r    <= err_c;
      occ_r      <= occ_nxt;
    end
  end

  assign rsp.valid     = out_valid_r;
  assign rsp.data_out  = data_out_r;
  assign rsp.error     = error_r;
  assign rsp.occupancy = occ_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count exceeds depth");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && err_c) |=> (fill_r == $past(fill_r)))
    else $error("refused request changed the fill count");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !err_c && (req.kind == KIND_PUSH_BACK)) |=>
      (fill_r == $past(fill_r) + CNT_W'(1)))
    else $error("accepted push did not grow the queue");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && error_r) |-> (data_out_r == '0))
    else $error("refused request returned data");

  a_no_shift_and_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_c.shift_en && cmd_c.wr_en))
    else $error("shift and write in the same cycle");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed deque. It drives push, pop, read and
// remove requests through the request channel, keeps its own copy of the
// queue contents, and compares every response word, error flag and
// occupancy against that copy while both channels idle at random.
// ----------------------------------------------------------------------------

module tb_top;
  import idq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 8;

  // Kinds the block does not know; it must refuse them
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
  } deque_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              error;
    logic [OCC_W-1:0]  occupancy;
  } deque_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  idq_req_if in_req ();
  idq_rsp_if out_rsp ();

  indexed_deque dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #5 clk = ~clk;

  // Shadow of the queue contents, front at index 0
  logic [VAL_W-1:0] shadow_words[$];
  // Responses owed by the block, oldest first
  deque_rsp_t       owed_rsp[$];

  int sender_idle_pct;
  int recv_idle_pct;
  int cycle_count;
  int mismatches;
  int requests_sent;
  int responses_seen;
  int refused_seen;
  int full_pushes;
  int peak_occupancy;

  // --------------------------------------------------------------------------
  // Predict one response and advance the shadow queue. A refused request
  // leaves the shadow untouched and returns a zero word.
  // --------------------------------------------------------------------------
  function automatic deque_rsp_t deque_apply(deque_req_t req);
    deque_rsp_t rsp;
    rsp = '0;
    case (req.kind)
      KIND_PUSH_BACK: begin
        if (shadow_words.size() >= DEPTH) begin
          rsp.error = 1'b1;
          full_pushes++;
        end else begin
          shadow_words.push_back(req.value);
        end
      end
      KIND_POP_FRONT: begin
        if (shadow_words.size() == 0) rsp.error = 1'b1;
        else rsp.data_out = shadow_words.pop_front();
      end
      KIND_POP_BACK: begin
        if (shadow_words.size() == 0) rsp.error = 1'b1;
        else rsp.data_out = shadow_words.pop_back();
      end
      KIND_READ_AT: begin
        if (int'(req.position) >= shadow_words.size()) rsp.error = 1'b1;
        else rsp.data_out = shadow_words[req.position];
      end
      KIND_REMOVE_AT: begin
        // Close the gap: every word behind the slot moves one step forward
        if (int'(req.position) >= shadow_words.size()) begin
          rsp.error = 1'b1;
        end else begin
          rsp.data_out = shadow_words[req.position];
          shadow_words.delete(req.position);
        end
      end
      default: rsp.error = 1'b1;
    endcase
    rsp.occupancy = OCC_W'(shadow_words.size());
    if (shadow_words.size() > peak_occupancy) peak_occupancy = shadow_words.size();
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Send one request. Drive on the falling edge, hold until the rising edge
  // that sees valid and ready together, then predict its response. Valid is
  // left high so back-to-back requests need no extra assignment.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [POS_W-1:0]  position,
                              input logic [VAL_W-1:0]  value);
    deque_req_t req;
    req.kind     = kind;
    req.position = position;
    req.value    = value;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.kind     <= kind;
    in_req.position <= position;
    in_req.value    <= value;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    owed_rsp.push_back(deque_apply(req));
    requests_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Response side: stall at random on the falling edge, check on the rising
  // edge against the oldest owed response.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    deque_rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      responses_seen++;
      if (owed_rsp.size() == 0) begin
        $display("%0t: response with none owed: data_out %h error %0d occupancy %0d",
                 $time, out_rsp.data_out, out_rsp.error, out_rsp.occupancy);
        mismatches++;
      end else begin
        want = owed_rsp.pop_front();
        if (want.error) refused_seen++;
        if (out_rsp.data_out !== want.data_out) begin
          $display("%0t: data_out expected %h, got %h",
                   $time, want.data_out, out_rsp.data_out);
          mismatches++;
        end
        if (out_rsp.error !== want.error) begin
          $display("%0t: error expected %0d, got %0d",
                   $time, want.error, out_rsp.error);
          mismatches++;
        end
        if (out_rsp.occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d, got %0d",
                   $time, want.occupancy, out_rsp.occupancy);
          mismatches++;
        end
      end
    end
  end

  // Count cycles for the watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("tb_top: timeout after %0d cycles", cycle_count);
    $display("tb_top: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Every pop, read and remove on an empty queue is refused; unknown kinds always are
  task automatic test_empty_refusals();
    send_request(KIND_POP_FRONT, '0, $urandom());
    send_request(KIND_POP_BACK, '1, $urandom());
    send_request(KIND_READ_AT, '0, $urandom());
    send_request(KIND_REMOVE_AT, '1, $urandom());
    send_request(KIND_UNUSED_LO, '0, $urandom());
    send_request(KIND_UNUSED_HI, '1, '1);
  endtask

  // Push extreme words and read them back at both ends and past the back
  task automatic test_word_extremes();
    send_request(KIND_PUSH_BACK, '1, 32'h0000_0000);
    send_request(KIND_PUSH_BACK, '0, 32'hFFFF_FFFF);
    send_request(KIND_PUSH_BACK, '1, 32'hA5A5_A5A5);
    send_request(KIND_PUSH_BACK, '0, 32'h5A5A_5A5A);
    send_request(KIND_PUSH_BACK, '0, 32'h0000_0001);
    send_request(KIND_PUSH_BACK, '0, 32'h8000_0000);
    send_request(KIND_READ_AT, 6'd0, $urandom());
    send_request(KIND_READ_AT, 6'd5, $urandom());
    send_request(KIND_READ_AT, 6'd6, $urandom());
    send_request(KIND_READ_AT, '1, $urandom());
  endtask

  // Remove in the middle, at the back, past the back and at the front
  task automatic test_indexed_remove();
    send_request(KIND_REMOVE_AT, 6'd2, $urandom());
    send_request(KIND_REMOVE_AT, 6'd4, $urandom());
    send_request(KIND_REMOVE_AT, 6'd4, $urandom());
    send_request(KIND_REMOVE_AT, 6'd0, $urandom());
  endtask

  // Drain from both ends, then pop once more on the empty queue
  task automatic test_drain_both_ends();
    send_request(KIND_POP_FRONT, POS_W'($urandom()), $urandom());
    send_request(KIND_POP_BACK, POS_W'($urandom()), $urandom());
    send_request(KIND_POP_BACK, POS_W'($urandom()), $urandom());
    send_request(KIND_POP_FRONT, POS_W'($urandom()), $urandom());
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. push_pct steers the fill level: high values run the
  // queue up to full and keep pushing into it, low values drain it to empty.
  // Positions mostly land inside the queue so reads and removes succeed.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int count, input int push_pct);
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
    int                pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < push_pct) kind = KIND_PUSH_BACK;
      else if (pick < 24) kind = KIND_POP_FRONT;
      else if (pick < 48) kind = KIND_POP_BACK;
      else if (pick < 72) kind = KIND_READ_AT;
      else if (pick < 96) kind = KIND_REMOVE_AT;
      else kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));

      if (shadow_words.size() > 0 && $urandom_range(99) < 85)
        position = POS_W'($urandom_range(shadow_words.size() - 1));
      else
        position = POS_W'($urandom_range(DEPTH - 1));

      pick = $urandom_range(19);
      if (pick == 0) value = '0;
      else if (pick == 1) value = '1;
      else value = $urandom();

      send_request(kind, position, value);
    end
  endtask

  // One idling setting: fill up to full, then drain past empty
  task automatic test_fill_and_drain(input int sender_pct, input int recv_pct);
    sender_idle_pct = sender_pct;
    recv_idle_pct   = recv_pct;
    test_random_traffic(100, 80);
    test_random_traffic(100, 15);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Hold every input at a known value from time zero
    rst_n            = 1'b0;
    in_req.valid     = 1'b0;
    in_req.kind      = '0;
    in_req.position  = '0;
    in_req.value     = '0;
    out_rsp.ready    = 1'b0;
    sender_idle_pct  = 21;
    recv_idle_pct    = 86;
    cycle_count      = 0;
    mismatches       = 0;
    requests_sent    = 0;
    responses_seen   = 0;
    refused_seen     = 0;
    full_pushes      = 0;
    peak_occupancy   = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_refusals();
    test_word_extremes();
    test_indexed_remove();
    test_drain_both_ends();

    test_fill_and_drain(21, 86);
    test_fill_and_drain(86, 21);
    test_fill_and_drain(0, 0);

    // Drop valid, let owed responses drain, then allow a short tail
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb_top: %0d requests, %0d responses checked, %0d refused",
             requests_sent, responses_seen, refused_seen);
    $display("tb_top: peak occupancy %0d, %0d pushes refused on a full queue",
             peak_occupancy, full_pushes);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
src/idq_pkg.sv
src/idq_ifs.sv
src/idq_cell.sv
src/idq_ctrl.sv
src/indexed_deque.sv
tb/sv/tb_top.sv
